/* rtl/core/ffba_pkg.sv */
// Shared types, widths and status codes of the first-fit block allocator.
package ffba_pkg;

  localparam int REQ_W = 14;
  localparam int OFS_W = 14;
  localparam int BLK_W = 6;

  localparam int HEAP_BYTES_DEF   = 8192;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;

  typedef enum logic [3:0] {
    ST_REUSED     = 4'd0,
    ST_NEW        = 4'd1,
    ST_ZERO       = 4'd2,
    ST_EXHAUSTED  = 4'd3,
    ST_TABLE_FULL = 4'd4,
    ST_FREED      = 4'd5,
    ST_DOUBLE     = 4'd6,
    ST_NOT_FOUND  = 4'd7,
    ST_NULL       = 4'd8
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef struct packed {
    logic             action;
    logic [REQ_W-1:0] request_bytes;
    logic [OFS_W-1:0] release_offset;
  } in_req_t;

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] payload_offset;
    logic [BLK_W-1:0] block_number;
  } out_rsp_t;

  // Search token handed from cell to cell; done marks that a cell has claimed it.
  typedef struct packed {
    logic             valid;
    logic             action;
    logic [REQ_W-1:0] request_bytes;
    logic [OFS_W-1:0] release_offset;
    logic             done;
    status_t          status;
    logic [OFS_W-1:0] payload_offset;
    logic [BLK_W-1:0] block_number;
  } probe_t;

endpackage

/* rtl/core/first_fit_block_allocator.sv */
// First-fit block allocator: a row of table cells searched by a travelling token.
// Usage:
//   Input channel in_valid / in_stall / in_data carries one request: allocate
//   request_bytes (action 0) or free release_offset (action 1). A request is taken
//   when in_valid is high and in_stall low. The block works on one request at a time
//   and holds in_stall high from acceptance until the result is loaded.
//   Result channel out_valid / out_stall / out_data gives status, payload offset
//   and block number; a result leaves when out_valid is high and out_stall low.
// Flow:
//   A zero-size allocate or a null free goes straight to the finish state and then
//   to the output register. Any other request is searched first, the token passing
//   one table cell per cycle through all MAX_BLOCKS cells to the finish state.
// Reset (synchronous, rst_n low) empties the table and the heap top pointer and
// drops any pending request and result. The table cells hold no reset values;
// only entries below the block count are ever consulted.
// Stall: a finished result waits in the search holding stage while the output
// register is occupied and stalled; an append is committed when it moves on, and
// the input stays stalled meanwhile.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_data
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int TW = $clog2(HEAP_BYTES + 1);
  localparam int SW = $clog2(HEAP_BYTES + (1 << REQ_W) + HEADER_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [TW-1:0] top_r, top_nxt;
  probe_t        pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_r, out_nxt;

  probe_t        chain [MAX_BLOCKS+1];

  logic          accept;
  logic          trivial;
  logic          out_free;
  logic [SW-1:0] new_top;
  logic [SW-1:0] new_pay;
  out_rsp_t      res;
  logic          do_append;
  logic          do_saturate;
  logic          wr_en;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign trivial  = (in_data.action == ACT_FREE) ? (in_data.release_offset == '0)
                                                  : (in_data.request_bytes == '0);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    chain[0]                = '0;
    chain[0].valid          = accept && !trivial;
    chain[0].action         = in_data.action;
    chain[0].request_bytes  = in_data.request_bytes;
    chain[0].release_offset = in_data.release_offset;
    chain[0].status         = ST_NOT_FOUND;
  end

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffba_cell #(
      .IDX          (g),
      .CW           (CW),
      .IW           (IW),
      .TW           (TW),
      .SW           (SW),
      .HEADER_BYTES (HEADER_BYTES)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .block_count (count_r),
      .probe_i     (chain[g]),
      .probe_o     (chain[g+1]),
      .wr_en       (wr_en),
      .wr_idx      (count_r[IW-1:0]),
      .wr_size     (pend_r.request_bytes),
      .wr_start    (top_r)
    );
  end

  assign new_top = SW'(top_r) + SW'(pend_r.request_bytes) + SW'(HEADER_BYTES);
  assign new_pay = SW'(top_r) + SW'(HEADER_BYTES);

  // Settle the outcome of a request whose search is over.
  always_comb begin
    res         = '0;
    do_append   = 1'b0;
    do_saturate = 1'b0;
    if (pend_r.done) begin
      res.status         = pend_r.status;
      res.payload_offset = pend_r.payload_offset;
      res.block_number   = pend_r.block_number;
    end else if (pend_r.action == ACT_FREE) begin
      res.status = ST_NOT_FOUND;
    end else if (count_r >= CW'(MAX_BLOCKS)) begin
      res.status = ST_TABLE_FULL;
    end else if (new_top >= SW'(HEAP_BYTES)) begin
      res.status  = ST_EXHAUSTED;
      do_saturate = 1'b1;
    end else begin
      res.status         = ST_NEW;
      res.payload_offset = new_pay[OFS_W-1:0];
      res.block_number   = BLK_W'(count_r);
      do_append          = 1'b1;
    end
  end

  assign wr_en = (state_r == S_FIN) && out_free && do_append;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (trivial) begin
            pend_nxt                = '0;
            pend_nxt.valid          = 1'b1;
            pend_nxt.action         = in_data.action;
            pend_nxt.done           = 1'b1;
            pend_nxt.status         = (in_data.action == ACT_FREE) ? ST_NULL : ST_ZERO;
            state_nxt               = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (chain[MAX_BLOCKS].valid) begin
          pend_nxt  = chain[MAX_BLOCKS];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Commit table changes only together with the result leaving.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res;
          if (do_append) begin
            top_nxt   = new_top[TW-1:0];
            count_nxt = count_r + CW'(1);
          end else if (do_saturate) begin
            top_nxt = TW'(HEAP_BYTES);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/core/ffba_cell.sv */
// One block table entry with its stage of the search chain.
module ffba_cell import ffba_pkg::*; #(
  parameter int IDX          = 0,
  parameter int CW           = 7,
  parameter int IW           = 6,
  parameter int TW           = 14,
  parameter int SW           = 15,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CW-1:0]    block_count,
  input  probe_t           probe_i,
  output probe_t           probe_o,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_idx,
  input  logic [REQ_W-1:0] wr_size,
  input  logic [TW-1:0]    wr_start
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_W = IW'(IDX);

  logic [REQ_W-1:0] size_r;
  logic [TW-1:0]    start_r;
  logic             free_r;
  logic             free_nxt;
  probe_t           probe_r;
  probe_t           probe_nxt;

  logic             live;
  logic [SW-1:0]    pay_ofs;
  logic             hit_alloc;
  logic             hit_free;

  assign live    = probe_i.valid && !probe_i.done && (IDX_C < block_count);
  assign pay_ofs = SW'(start_r) + SW'(HEADER_BYTES);
  assign hit_alloc = live && (probe_i.action == ACT_ALLOC) && free_r &&
                     (size_r >= probe_i.request_bytes);
  assign hit_free  = live && (probe_i.action == ACT_FREE) &&
                     (pay_ofs == SW'(probe_i.release_offset));

  always_comb begin
    probe_nxt = probe_i;
    free_nxt  = free_r;
    if (hit_alloc) begin
      free_nxt                 = 1'b0;
      probe_nxt.done           = 1'b1;
      probe_nxt.status         = ST_REUSED;
      probe_nxt.payload_offset = pay_ofs[OFS_W-1:0];
      probe_nxt.block_number   = BLK_W'(IDX);
    end else if (hit_free) begin
      free_nxt                 = 1'b1;
      probe_nxt.done           = 1'b1;
      probe_nxt.status         = free_r ? ST_DOUBLE : ST_FREED;
      probe_nxt.payload_offset = probe_i.release_offset;
      probe_nxt.block_number   = BLK_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  // Append write and search never overlap: the chain is empty while appending.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W)) begin
      size_r  <= wr_size;
      start_r <= wr_start;
      free_r  <= 1'b0;
    end else begin
      free_r  <= free_nxt;
    end
  end

  assign probe_o = probe_r;

endmodule

/* verif/first_fit_block_allocator_tb.sv */
// Self-checking testbench for the first-fit block allocator, with a shadow heap table.
module first_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam int HEAP = HEAP_BYTES_DEF;
  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam int HDR = HEADER_BYTES_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * (NBLK + 3) + 8;
  localparam int HOLD_OFF_CYCLES = 800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_data;

  // shadow of the block table and bump pointer
  logic [REQ_W-1:0] shadow_size[NBLK];
  bit shadow_free[NBLK];
  logic [OFS_W-1:0] shadow_start[NBLK];
  int unsigned shadow_count = 0;
  int unsigned shadow_top = 0;

  out_rsp_t pending_rsp[$];
  int mismatch_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int sink_hold = 0;
  int quiet_cycles = 0;

  first_fit_block_allocator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the shadow table and return the response it must produce.
  function automatic out_rsp_t apply_heap_request(in_req_t r);
    out_rsp_t rsp;
    int unsigned new_top;
    rsp.status = ST_ZERO;
    rsp.payload_offset = '0;
    rsp.block_number = '0;
    if (r.action == ACT_ALLOC) begin
      if (r.request_bytes == '0) return rsp;
      for (int i = 0; i < shadow_count; i++) begin
        if (shadow_free[i] && shadow_size[i] >= r.request_bytes) begin
          shadow_free[i] = 1'b0;
          rsp.status = ST_REUSED;
          rsp.payload_offset = OFS_W'(shadow_start[i] + HDR);
          rsp.block_number = BLK_W'(i);
          return rsp;
        end
      end
      if (shadow_count >= NBLK) begin
        rsp.status = ST_TABLE_FULL;
        return rsp;
      end
      new_top = shadow_top + r.request_bytes + HDR;
      if (new_top >= HEAP) begin
        // a failed append still pins the top at the heap end
        shadow_top = HEAP;
        rsp.status = ST_EXHAUSTED;
        return rsp;
      end
      shadow_size[shadow_count] = r.request_bytes;
      shadow_free[shadow_count] = 1'b0;
      shadow_start[shadow_count] = OFS_W'(shadow_top);
      rsp.status = ST_NEW;
      rsp.payload_offset = OFS_W'(shadow_top + HDR);
      rsp.block_number = BLK_W'(shadow_count);
      shadow_top = new_top;
      shadow_count++;
      return rsp;
    end
    if (r.release_offset == '0) begin
      rsp.status = ST_NULL;
      return rsp;
    end
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_start[i] + HDR == r.release_offset) begin
        rsp.payload_offset = r.release_offset;
        rsp.block_number = BLK_W'(i);
        if (shadow_free[i]) begin
          rsp.status = ST_DOUBLE;
        end else begin
          shadow_free[i] = 1'b1;
          rsp.status = ST_FREED;
        end
        return rsp;
      end
    end
    rsp.status = ST_NOT_FOUND;
    return rsp;
  endfunction

  // Unused field of each request carries random junk.
  function automatic in_req_t alloc_req(int unsigned bytes);
    in_req_t r;
    r.action = ACT_ALLOC;
    r.request_bytes = REQ_W'(bytes);
    r.release_offset = OFS_W'($urandom);
    return r;
  endfunction

  function automatic in_req_t free_req(int unsigned ofs);
    in_req_t r;
    r.action = ACT_FREE;
    r.request_bytes = REQ_W'($urandom);
    r.release_offset = OFS_W'(ofs);
    return r;
  endfunction

  // Random table index whose free flag matches, or -1 when there is none.
  function automatic int pick_block(bit want_free);
    int cand[$];
    for (int i = 0; i < shadow_count; i++)
      if (shadow_free[i] == want_free) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  task automatic send_request(in_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pending_rsp.push_back(apply_heap_request(r));
  endtask

  // Receiver: honor a long hold-off first, otherwise stall at random.
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_stall <= 1'b1;
      sink_hold--;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none outstanding: status %0d offset %0d block %0d",
                 $time, out_data.status, out_data.payload_offset, out_data.block_number);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          mismatch_count++;
        end
        if (out_data.payload_offset !== want.payload_offset) begin
          $display("%0t: payload_offset expected %0d actual %0d", $time,
                   want.payload_offset, out_data.payload_offset);
          mismatch_count++;
        end
        if (out_data.block_number !== want.block_number) begin
          $display("%0t: block_number expected %0d actual %0d", $time,
                   want.block_number, out_data.block_number);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without any handshake on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no request or response moved in %0d cycles", $time,
               QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_edge_cases();
    send_request(alloc_req(0));
    send_request(free_req(0));
    send_request(free_req(14'h3FFF));
    send_request(alloc_req(1));
    send_request(free_req(HDR + 1));
    send_request(free_req(HDR));
    send_request(free_req(HDR));
    // freed block is too small, so this appends
    send_request(alloc_req(2));
    send_request(alloc_req(1));
    send_request(alloc_req(40));
    send_request(alloc_req(40));
    send_request(free_req(shadow_start[3] + HDR));
    send_request(free_req(shadow_start[2] + HDR));
    // first fit must take the lower of two equal free blocks
    send_request(alloc_req(30));
    send_request(alloc_req(30));
    // a header address is not a payload pointer
    send_request(free_req(shadow_start[2]));
  endtask

  // Grow the table to two short of full with small blocks, freeing some on the way.
  task automatic test_table_build();
    int i;
    while (shadow_count < NBLK - 2) begin
      i = pick_block(1'b0);
      if ($urandom_range(99) < 20 && i >= 0)
        send_request(free_req(shadow_start[i] + HDR));
      else
        send_request(alloc_req($urandom_range(1, 100)));
    end
  endtask

  // A heap-end failure pins the top for good, so no later append can fill the table;
  // this run spends its last append on the heap boundary instead of the table limit.
  task automatic test_heap_end();
    int first;
    first = 0;
    while (first >= 0) begin
      first = -1;
      for (int i = 0; i < shadow_count; i++) begin
        if (shadow_free[i]) begin
          first = i;
          break;
        end
      end
      if (first >= 0) send_request(alloc_req(shadow_size[first]));
    end
    // leave the top exactly HDR + 2 short of the heap end
    send_request(alloc_req(HEAP - 2 * HDR - 2 - shadow_top));
    send_request(alloc_req(2));
    // would fit below the end if the top had not saturated
    send_request(alloc_req(1));
    send_request(alloc_req(14'h3FFF));
    send_request(alloc_req(14'h2000));
  endtask

  task automatic test_backpressure();
    int i;
    @(posedge clk);
    sink_hold = HOLD_OFF_CYCLES;
    repeat (6) begin
      i = pick_block(1'b0);
      if (i >= 0 && $urandom_range(1))
        send_request(free_req(shadow_start[i] + HDR));
      else
        send_request(alloc_req($urandom_range(1, 120)));
    end
  endtask

  task automatic test_random_traffic(int count);
    int sel;
    int i;
    in_req_t r;
    repeat (count) begin
      sel = $urandom_range(99);
      i = $urandom_range(shadow_count - 1);
      if (sel < 30) begin
        i = pick_block(1'b0);
        r = (i >= 0) ? free_req(shadow_start[i] + HDR) : alloc_req($urandom_range(1, 200));
      end else if (sel < 38) begin
        i = pick_block(1'b1);
        r = (i >= 0) ? free_req(shadow_start[i] + HDR) : free_req(0);
      end else if (sel < 73) begin
        r = alloc_req($urandom_range(1, shadow_size[i]));
      end else if (sel < 78) begin
        r = alloc_req(0);
      end else if (sel < 82) begin
        r = free_req(0);
      end else if (sel < 88) begin
        r = free_req($urandom_range(1, 14'h3FFF));
      end else if (sel < 93) begin
        // near miss around a real payload pointer
        r = free_req(shadow_start[i] + HDR + ($urandom_range(1) ? 1 : -1));
      end else begin
        r = alloc_req($urandom_range(1, 14'h3FFF));
      end
      send_request(r);
    end
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rsp.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    src_idle_pct = 35;
    sink_idle_pct = 76;
    test_edge_cases();
    test_table_build();
    test_heap_end();
    test_backpressure();
    test_random_traffic(490);
    src_idle_pct = 76;
    sink_idle_pct = 35;
    test_random_traffic(490);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(490);
    finish_run();
  end

endmodule
